// ===== design/sacal_pkg.sv =====
package sacal_pkg;

  localparam int DEF_MAX_SET_BITS = 6;
  localparam int DEF_MAX_WAYS     = 8;

  localparam int TAG_W      = 32;
  localparam int AGE_W      = 8;
  localparam int TOTAL_W    = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 6;

  localparam logic [AGE_W-1:0] AGE_TOP = 8'd255;

  localparam logic [CFG_IDX_W-1:0] CFG_SET_BITS    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_BITS  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WAYS_IN_USE = 2'd2;

  typedef enum logic [1:0] {
    MODE_LOAD   = 2'd0,
    MODE_STORE  = 2'd1,
    MODE_MODIFY = 2'd2,
    MODE_FETCH  = 2'd3
  } mode_t;

  typedef struct packed {
    mode_t       mode;
    logic [63:0] address;
  } in_item_t;

  typedef struct packed {
    logic               was_ignored;
    logic               was_hit;
    logic               was_eviction;
    logic [2:0]         way_touched;
    logic [TOTAL_W-1:0] total_hits;
    logic [TOTAL_W-1:0] total_misses;
    logic [TOTAL_W-1:0] total_evictions;
  } out_item_t;

  typedef struct packed {
    logic             valid;
    logic [TAG_W-1:0] tag;
    logic [AGE_W-1:0] age;
  } line_t;

  typedef struct packed {
    logic hit;
    logic evict;
  } lkp_flags_t;

  function automatic logic [TOTAL_W-1:0] sat_add(input logic [TOTAL_W-1:0] v,
                                                 input logic [1:0] n);
    logic [TOTAL_W:0] s;
    s = {1'b0, v} + {{(TOTAL_W-1){1'b0}}, n};
    return s[TOTAL_W] ? {TOTAL_W{1'b1}} : s[TOTAL_W-1:0];
  endfunction

endpackage

// ===== design/sacal_ram.sv =====
module sacal_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic                                     re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== design/sacal_addr.sv =====
module sacal_addr #(
  parameter int MAX_SET_BITS = sacal_pkg::DEF_MAX_SET_BITS
) (
  input  logic [63:0]                                    address,
  input  logic [2:0]                                     set_bits,
  input  logic [5:0]                                     block_bits,
  output logic [((MAX_SET_BITS > 0) ? MAX_SET_BITS : 1)-1:0] set_o,
  output logic [sacal_pkg::TAG_W-1:0]                    tag_o
);
  import sacal_pkg::*;

  localparam int SET_W = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;

  logic [3:0]  sb;
  logic [6:0]  tag_shamt;
  logic [63:0] set_sh;
  logic [63:0] tag_sh;

  always_comb begin
    sb = ({1'b0, set_bits} > 4'(MAX_SET_BITS)) ? 4'(MAX_SET_BITS) : {1'b0, set_bits};
    set_sh = address >> block_bits;
    for (int i = 0; i < SET_W; i++) begin
      set_o[i] = set_sh[i] & (4'(i) < sb);
    end
    tag_shamt = {1'b0, block_bits} + {3'b000, sb};
    tag_sh = address >> tag_shamt;
    tag_o = tag_sh[TAG_W-1:0];
  end

endmodule

// ===== design/sacal_lookup.sv =====
module sacal_lookup #(
  parameter int MAX_WAYS = sacal_pkg::DEF_MAX_WAYS
) (
  input  sacal_pkg::line_t [MAX_WAYS-1:0]              row_i,
  input  logic [sacal_pkg::TAG_W-1:0]                  tag_i,
  input  logic [$clog2(MAX_WAYS+1)-1:0]                ways_i,
  output sacal_pkg::line_t [MAX_WAYS-1:0]              row_o,
  output logic [((MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1)-1:0] way_o,
  output sacal_pkg::lkp_flags_t                        flags_o
);
  import sacal_pkg::*;

  localparam int WAY_W  = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int WCNT_W = $clog2(MAX_WAYS + 1);

  logic             hit_found;
  logic [WAY_W-1:0] hit_way;
  logic             inv_found;
  logic [WAY_W-1:0] inv_way;
  logic             vic_found;
  logic [WAY_W-1:0] vic_way;
  logic [AGE_W-1:0] vic_age;

  always_comb begin
    hit_found = 1'b0;
    hit_way   = '0;
    inv_found = 1'b0;
    inv_way   = '0;
    vic_found = 1'b0;
    vic_way   = '0;
    vic_age   = '0;
    for (int w = 0; w < MAX_WAYS; w++) begin
      if (WCNT_W'(w) < ways_i) begin
        if (row_i[w].valid) begin
          if (!hit_found && row_i[w].tag == tag_i) begin
            hit_found = 1'b1;
            hit_way   = WAY_W'(w);
          end
          if (!vic_found || row_i[w].age < vic_age) begin
            vic_found = 1'b1;
            vic_way   = WAY_W'(w);
            vic_age   = row_i[w].age;
          end
        end else if (!inv_found) begin
          inv_found = 1'b1;
          inv_way   = WAY_W'(w);
        end
      end
    end

    flags_o.hit   = hit_found;
    flags_o.evict = !hit_found && !inv_found;
    way_o = hit_found ? hit_way : (inv_found ? inv_way : vic_way);

    row_o = row_i;
    for (int w = 0; w < MAX_WAYS; w++) begin
      if (WCNT_W'(w) < ways_i) begin
        if (row_i[w].age != '0) begin
          row_o[w].age = row_i[w].age - AGE_W'(1);
        end
        if (way_o == WAY_W'(w)) begin
          row_o[w].age = AGE_TOP;
          if (!hit_found) begin
            row_o[w].valid = 1'b1;
            row_o[w].tag   = tag_i;
          end
        end
      end
    end
  end

endmodule

// ===== design/set_assoc_cache_aging_lru.sv =====
// Set-associative cache model with aging replacement. Each input item is one access (load,
// store, modify or instruction fetch) with a 64-bit byte address; each one gives exactly one
// result item with hit/eviction flags, the way touched and saturating hit, miss and eviction
// totals. On accept the whole set (all ways, one row) is read from a synchronous RAM; the
// lookup state then, once the result register is free, does tag match, victim pick, aging
// and writes the row back (fetches are ignored and write nothing); a new item is taken only
// after that. After reset the RAM is swept clean, one set per cycle, over all
// 2**MAX_SET_BITS sets (64 by default); in_stall stays high until then, configuration writes
// are taken throughout. Configuration may only be written while no item is in flight.
module set_assoc_cache_aging_lru #(
  parameter int MAX_SET_BITS = sacal_pkg::DEF_MAX_SET_BITS,
  parameter int MAX_WAYS     = sacal_pkg::DEF_MAX_WAYS
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [sacal_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sacal_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  sacal_pkg::in_item_t             in_item,
  output logic                            out_valid,
  input  logic                            out_stall,
  output sacal_pkg::out_item_t            out_item
);
  import sacal_pkg::*;

  localparam int DEPTH  = 1 << MAX_SET_BITS;
  localparam int SET_W  = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
  localparam int WAY_W  = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int WCNT_W = $clog2(MAX_WAYS + 1);
  localparam int ROW_W  = MAX_WAYS * $bits(line_t);

  typedef enum logic [1:0] {ST_CLEAR, ST_IDLE, ST_LOOK} state_t;

  state_t             state_r, state_nxt;
  logic [SET_W-1:0]   clr_r, clr_nxt;
  logic [2:0]         set_bits_r, set_bits_nxt;
  logic [5:0]         block_bits_r, block_bits_nxt;
  logic [3:0]         ways_in_use_r, ways_in_use_nxt;
  logic [TOTAL_W-1:0] hits_r, hits_nxt;
  logic [TOTAL_W-1:0] misses_r, misses_nxt;
  logic [TOTAL_W-1:0] evicts_r, evicts_nxt;
  logic               out_valid_r, out_valid_nxt;
  out_item_t          out_item_r, out_item_nxt;
  logic [SET_W-1:0]   set_r, set_nxt;
  logic [TAG_W-1:0]   tag_r, tag_nxt;
  mode_t              mode_r, mode_nxt;

  logic [SET_W-1:0]           set_c;
  logic [TAG_W-1:0]           tag_c;
  logic [WCNT_W-1:0]          ways;
  logic                       accept;
  logic                       look_fire;
  logic                       fetch;
  logic                       ram_we;
  logic [SET_W-1:0]           ram_waddr;
  logic [ROW_W-1:0]           ram_wdata;
  logic [ROW_W-1:0]           ram_rdata;
  line_t [MAX_WAYS-1:0]       row_rd;
  line_t [MAX_WAYS-1:0]       row_wr;
  logic [WAY_W-1:0]           way;
  lkp_flags_t                 flags;
  logic [WAY_W+2:0]           way_ext;

  sacal_addr #(
    .MAX_SET_BITS(MAX_SET_BITS)
  ) u_addr (
    .address   (in_item.address),
    .set_bits  (set_bits_r),
    .block_bits(block_bits_r),
    .set_o     (set_c),
    .tag_o     (tag_c)
  );

  sacal_ram #(
    .WIDTH(ROW_W),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (accept),
    .raddr(set_c),
    .rdata(ram_rdata)
  );

  assign row_rd = ram_rdata;

  sacal_lookup #(
    .MAX_WAYS(MAX_WAYS)
  ) u_lookup (
    .row_i  (row_rd),
    .tag_i  (tag_r),
    .ways_i (ways),
    .row_o  (row_wr),
    .way_o  (way),
    .flags_o(flags)
  );

  assign in_stall  = (state_r != ST_IDLE);
  assign accept    = in_valid && !in_stall;
  assign look_fire = (state_r == ST_LOOK) && (!out_valid_r || !out_stall);
  assign fetch     = (mode_r == MODE_FETCH);
  assign way_ext   = (WAY_W+3)'(way);

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  always_comb begin
    if (ways_in_use_r == 4'd0) begin
      ways = WCNT_W'(1);
    end else if ({28'd0, ways_in_use_r} > 32'(MAX_WAYS)) begin
      ways = WCNT_W'(MAX_WAYS);
    end else begin
      ways = WCNT_W'(ways_in_use_r);
    end
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = set_r;
    ram_wdata = row_wr;
    if (state_r == ST_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_r;
      ram_wdata = '0;
    end else if (look_fire && !fetch) begin
      ram_we = 1'b1;
    end
  end

  always_comb begin
    state_nxt       = state_r;
    clr_nxt         = clr_r;
    set_bits_nxt    = set_bits_r;
    block_bits_nxt  = block_bits_r;
    ways_in_use_nxt = ways_in_use_r;
    hits_nxt        = hits_r;
    misses_nxt      = misses_r;
    evicts_nxt      = evicts_r;
    out_valid_nxt   = out_valid_r;
    out_item_nxt    = out_item_r;
    set_nxt         = set_r;
    tag_nxt         = tag_r;
    mode_nxt        = mode_r;

    if (cfg_we) begin
      case (cfg_index)
        CFG_SET_BITS:    set_bits_nxt    = cfg_data[2:0];
        CFG_BLOCK_BITS:  block_bits_nxt  = cfg_data[5:0];
        CFG_WAYS_IN_USE: ways_in_use_nxt = cfg_data[3:0];
        default: ;
      endcase
    end

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_CLEAR: begin
        clr_nxt = clr_r + SET_W'(1);
        if (clr_r == SET_W'(DEPTH - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          set_nxt   = set_c;
          tag_nxt   = tag_c;
          mode_nxt  = in_item.mode;
          state_nxt = ST_LOOK;
        end
      end
      ST_LOOK: begin
        if (look_fire) begin
          hits_nxt   = sat_add(hits_r, {1'b0, !fetch && flags.hit}
                                       + {1'b0, mode_r == MODE_MODIFY});
          misses_nxt = sat_add(misses_r, {1'b0, !fetch && !flags.hit});
          evicts_nxt = sat_add(evicts_r, {1'b0, !fetch && flags.evict});
          out_item_nxt.was_ignored     = fetch;
          out_item_nxt.was_hit         = !fetch && flags.hit;
          out_item_nxt.was_eviction    = !fetch && flags.evict;
          out_item_nxt.way_touched     = fetch ? 3'd0 : way_ext[2:0];
          out_item_nxt.total_hits      = hits_nxt;
          out_item_nxt.total_misses    = misses_nxt;
          out_item_nxt.total_evictions = evicts_nxt;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_CLEAR;
      clr_r         <= '0;
      set_bits_r    <= 3'd0;
      block_bits_r  <= 6'd0;
      ways_in_use_r <= 4'd1;
      hits_r        <= '0;
      misses_r      <= '0;
      evicts_r      <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      clr_r         <= clr_nxt;
      set_bits_r    <= set_bits_nxt;
      block_bits_r  <= block_bits_nxt;
      ways_in_use_r <= ways_in_use_nxt;
      hits_r        <= hits_nxt;
      misses_r      <= misses_nxt;
      evicts_r      <= evicts_nxt;
      out_valid_r   <= out_valid_nxt;
    end
    out_item_r <= out_item_nxt;
    set_r      <= set_nxt;
    tag_r      <= tag_nxt;
    mode_r     <= mode_nxt;
  end

endmodule
